// ===== rtl/core/msfcb_pkg.sv =====
// Shared types and constants for the maximum spanning forest cycle breaker.
// Holds the request and result records, the micro-operation codes and the
// command and status records between the controller and the datapath.
package msfcb_pkg;

  localparam int VCOUNT_W     = 11;
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;
  localparam int RANK_W       = 4;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_SOLVE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_SUMMARY = 2'd0,
    KIND_EDGE    = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         src_vertex;
    logic [9:0]         dst_vertex;
    logic signed [15:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [9:0]         removed_src;
    logic [9:0]         removed_dst;
    logic signed [15:0] removed_weight;
    logic [12:0]        removed_count;
    logic signed [27:0] removed_total;
    logic               edge_overflow;
    logic               is_last;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_INIT_START,
    OP_INIT,
    OP_B_RD,
    OP_B_WR,
    OP_SORT_START,
    OP_SEG,
    OP_M_RD,
    OP_M_WR,
    OP_M_NEXT,
    OP_IDX_CLR,
    OP_K_KEY,
    OP_K_EDGE,
    OP_F_START,
    OP_F_RD,
    OP_F_CHK,
    OP_C_RD,
    OP_C_CHK,
    OP_L_RD,
    OP_L_WR,
    OP_I_INC,
    OP_CL_START,
    OP_CL_RD,
    OP_CL_WR,
    OP_EMIT_SUM,
    OP_R_KEY,
    OP_R_EDGE,
    OP_EMIT_EDGE,
    OP_EMIT_END
  } op_t;

  typedef struct packed {
    op_t  op;
    logic phase;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic vc_last;
    logic i_done;
    logic sort_done;
    logic seg_end;
    logic p_eq_r;
    logic on_dst;
    logic roots_same;
    logic ptr_lt;
  } sts_t;

endpackage

// ===== rtl/core/msfcb_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on msfcb_pkg for the payload records.
interface msfcb_in_if;
  logic                valid;
  logic                ready;
  msfcb_pkg::in_item_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

interface msfcb_out_if;
  logic                 valid;
  logic                 ready;
  msfcb_pkg::out_item_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/msfcb_datapath.sv =====
// Datapath: edge stores, sort key memories, union-find memories, counters
// and the result register. Driven by msfcb_ctrl through msfcb_pkg records.
module msfcb_datapath #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [msfcb_pkg::VCOUNT_W-1:0]      cfg_wr_data,
  input  msfcb_pkg::in_item_t                 in_item,
  input  msfcb_pkg::cmd_t                     cmd,
  output msfcb_pkg::sts_t                     sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output msfcb_pkg::out_item_t                out_item
);
  import msfcb_pkg::*;

  localparam int VB  = $clog2(MAX_VERTICES);
  localparam int IW  = $clog2(MAX_EDGES);
  localparam int NW  = $clog2(MAX_EDGES + 1);
  localparam int CW  = IW + 2;
  localparam int WB  = WEIGHT_BITS;
  localparam int K1W = WB + IW;
  localparam int K2W = 2 * VB + IW;
  localparam int KW  = (K1W > K2W) ? K1W : K2W;

  // Storage.
  logic [VB-1:0]     src_mem    [MAX_EDGES];
  logic [VB-1:0]     dst_mem    [MAX_EDGES];
  logic [WB-1:0]     wgt_mem    [MAX_EDGES];
  logic              kept_mem   [MAX_EDGES];
  logic [KW-1:0]     key0_mem   [MAX_EDGES];
  logic [KW-1:0]     key1_mem   [MAX_EDGES];
  logic [VB-1:0]     parent_mem [MAX_VERTICES];
  logic [RANK_W-1:0] rank_mem   [MAX_VERTICES];

  // Control and counters.
  logic [VCOUNT_W-1:0] vcount;
  logic [NW-1:0]       edge_total;
  logic                overflow_seen;
  logic [NW-1:0]       readout_pointer;
  logic [NW-1:0]       rej_cnt;
  logic [27:0]         rej_sum;
  logic [NW-1:0]       i;
  logic [VB-1:0]       vc;
  logic [NW-1:0]       sn;
  logic [CW-1:0]       w, lo, a, b, k;
  logic                sel;
  logic [IW-1:0]       idx;
  logic [VB-1:0]       x, r, ru;
  logic                on_dst;
  out_item_t           out_q;

  // Registered read data.
  logic [VB-1:0]     src_q, dst_q, pdata;
  logic [WB-1:0]     w_q;
  logic              kept_q;
  logic [KW-1:0]     k0a_q, k0b_q, k1a_q, k1b_q;
  logic [RANK_W-1:0] rank_a, rank_b;

  // Combinational helpers.
  logic [31:0]   in_src32, in_dst32, in_w32, veff;
  logic [VB-1:0] in_src, in_dst;
  logic          in_ok;
  logic [31:0]   w32, lo32, hi32, cnt32;
  logic [VB-1:0] lo_v, hi_v;
  logic [KW-1:0] key1, key2, ka, kb, res_a;
  logic [CW-1:0] sn_c, lo_w, lo_2w, mid, hi, lo_n;
  logic          take_a;
  logic [IW-1:0] ra_addr, rb_addr, er_addr, k_wa, kept_wa;
  logic          k0_we, k1_we, er_en, kept_we, kept_wd;
  logic [KW-1:0] k_wd;
  logic [VB-1:0] pa_ra, pa_wa, pa_wd, rk_wa;
  logic          pa_we, rk_we;
  logic [RANK_W-1:0] rk_wd;
  logic          emit_op;
  out_item_t     out_next;

  assign in_src32 = 32'(in_item.src_vertex);
  assign in_dst32 = 32'(in_item.dst_vertex);
  assign in_w32   = {16'd0, in_item.edge_weight};
  assign in_src   = in_src32[VB-1:0];
  assign in_dst   = in_dst32[VB-1:0];
  assign veff     = (32'(vcount) < 32'(MAX_VERTICES)) ? 32'(vcount) : 32'(MAX_VERTICES);
  assign in_ok    = (in_src32 < veff) && (in_dst32 < veff);

  assign w32   = 32'($signed(w_q));
  assign lo_v  = (src_q < dst_q) ? src_q : dst_q;
  assign hi_v  = (src_q < dst_q) ? dst_q : src_q;
  assign lo32  = 32'(lo_v);
  assign hi32  = 32'(hi_v);
  assign cnt32 = 32'(rej_cnt);

  // Kruskal key sorts ascending into decreasing weight, latest load first.
  assign key1 = KW'({w_q[WB-1], ~w_q[WB-2:0], ~i[IW-1:0]});
  assign key2 = KW'({lo_v, hi_v, i[IW-1:0]});

  assign ka    = sel ? k1a_q : k0a_q;
  assign kb    = sel ? k1b_q : k0b_q;
  assign res_a = ka;

  assign sn_c   = CW'(sn);
  assign lo_w   = lo + w;
  assign lo_2w  = lo + (w << 1);
  assign mid    = (lo_w < sn_c) ? lo_w : sn_c;
  assign hi     = (lo_2w < sn_c) ? lo_2w : sn_c;
  assign lo_n   = lo_2w;
  assign take_a = (a < mid) && ((b >= hi) || (ka <= kb));

  assign emit_op = cmd.op inside {OP_EMIT_SUM, OP_EMIT_EDGE, OP_EMIT_END};

  always_comb begin
    ra_addr = a[IW-1:0];
    rb_addr = b[IW-1:0];
    er_addr = i[IW-1:0];
    er_en   = 1'b0;
    k0_we   = 1'b0;
    k1_we   = 1'b0;
    k_wa    = i[IW-1:0];
    k_wd    = key1;
    kept_we = 1'b0;
    kept_wa = i[IW-1:0];
    kept_wd = 1'b0;
    pa_ra   = r;
    pa_we   = 1'b0;
    pa_wa   = vc;
    pa_wd   = vc;
    rk_we   = 1'b0;
    rk_wa   = vc;
    rk_wd   = '0;
    unique case (cmd.op)
      OP_INIT: begin
        pa_we = 1'b1;
        rk_we = 1'b1;
      end
      OP_B_RD: er_en = 1'b1;
      OP_B_WR: begin
        k0_we   = 1'b1;
        kept_we = 1'b1;
      end
      OP_M_WR: begin
        k0_we = sel;
        k1_we = ~sel;
        k_wa  = k[IW-1:0];
        k_wd  = take_a ? ka : kb;
      end
      OP_K_KEY: ra_addr = i[IW-1:0];
      OP_K_EDGE: begin
        er_en   = 1'b1;
        er_addr = ~res_a[IW-1:0];
      end
      OP_C_RD: pa_ra = x;
      OP_C_CHK: begin
        pa_we = (pdata != r);
        pa_wa = x;
        pa_wd = r;
      end
      OP_L_WR: begin
        pa_we   = 1'b1;
        kept_we = 1'b1;
        kept_wa = idx;
        kept_wd = 1'b1;
        if (rank_a > rank_b) begin
          pa_wa = r;
          pa_wd = ru;
        end else begin
          pa_wa = ru;
          pa_wd = r;
          rk_we = (rank_a == rank_b);
          rk_wa = r;
          rk_wd = RANK_W'(rank_b + 1'b1);
        end
      end
      OP_CL_RD: er_en = 1'b1;
      OP_CL_WR: begin
        k0_we = ~kept_q;
        k_wa  = rej_cnt[IW-1:0];
        k_wd  = key2;
      end
      OP_R_KEY: ra_addr = readout_pointer[IW-1:0];
      OP_R_EDGE: begin
        er_en   = 1'b1;
        er_addr = res_a[IW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    out_next = '0;
    unique case (cmd.op)
      OP_EMIT_SUM: begin
        out_next.result_kind   = KIND_SUMMARY;
        out_next.removed_count = cnt32[12:0];
        out_next.removed_total = rej_sum;
        out_next.edge_overflow = overflow_seen;
      end
      OP_EMIT_EDGE: begin
        out_next.result_kind    = KIND_EDGE;
        out_next.removed_src    = lo32[9:0];
        out_next.removed_dst    = hi32[9:0];
        out_next.removed_weight = w32[15:0];
        out_next.is_last        = (readout_pointer + 1'b1 == rej_cnt);
      end
      default: out_next.result_kind = KIND_END;
    endcase
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && in_ok && edge_total != NW'(MAX_EDGES)) begin
      src_mem[edge_total[IW-1:0]] <= in_src;
      dst_mem[edge_total[IW-1:0]] <= in_dst;
      wgt_mem[edge_total[IW-1:0]] <= in_w32[WB-1:0];
    end
    if (er_en) begin
      src_q <= src_mem[er_addr];
      dst_q <= dst_mem[er_addr];
      w_q   <= wgt_mem[er_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (kept_we) kept_mem[kept_wa] <= kept_wd;
    if (er_en) kept_q <= kept_mem[er_addr];
  end

  always_ff @(posedge clk) begin
    if (k0_we) key0_mem[k_wa] <= k_wd;
    if (k1_we) key1_mem[k_wa] <= k_wd;
    k0a_q <= key0_mem[ra_addr];
    k0b_q <= key0_mem[rb_addr];
    k1a_q <= key1_mem[ra_addr];
    k1b_q <= key1_mem[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (pa_we) parent_mem[pa_wa] <= pa_wd;
    pdata <= parent_mem[pa_ra];
  end

  always_ff @(posedge clk) begin
    if (rk_we) rank_mem[rk_wa] <= rk_wd;
    rank_a <= rank_mem[ru];
    rank_b <= rank_mem[r];
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount          <= VCOUNT_RESET;
      edge_total      <= '0;
      overflow_seen   <= 1'b0;
      readout_pointer <= '0;
      rej_cnt         <= '0;
      rej_sum         <= '0;
      out_valid       <= 1'b0;
      sel             <= 1'b0;
    end else begin
      if (cfg_wr_en) vcount <= cfg_wr_data;
      if (emit_op) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (cmd.op)
        OP_LOAD: begin
          if (in_ok) begin
            if (edge_total == NW'(MAX_EDGES)) overflow_seen <= 1'b1;
            else edge_total <= edge_total + 1'b1;
          end
        end
        OP_INIT_START: begin
          vc <= '0;
          i  <= '0;
        end
        OP_INIT: vc <= vc + 1'b1;
        OP_B_WR: i <= i + 1'b1;
        OP_SORT_START: begin
          sn  <= cmd.phase ? rej_cnt : edge_total;
          w   <= CW'(1);
          lo  <= '0;
          sel <= 1'b0;
        end
        OP_SEG: begin
          a <= lo;
          b <= mid;
          k <= lo;
        end
        OP_M_WR: begin
          if (take_a) a <= a + 1'b1;
          else b <= b + 1'b1;
          k <= k + 1'b1;
        end
        OP_M_NEXT: begin
          if (lo_n >= sn_c) begin
            lo  <= '0;
            w   <= w << 1;
            sel <= ~sel;
          end else begin
            lo <= lo_n;
          end
        end
        OP_IDX_CLR: i <= '0;
        OP_K_KEY: on_dst <= 1'b0;
        OP_K_EDGE: idx <= ~res_a[IW-1:0];
        OP_F_START: begin
          x <= on_dst ? dst_q : src_q;
          r <= on_dst ? dst_q : src_q;
        end
        OP_F_CHK: if (pdata != r) r <= pdata;
        OP_C_CHK: begin
          if (pdata != r) begin
            x <= pdata;
          end else if (!on_dst) begin
            ru     <= r;
            on_dst <= 1'b1;
          end
        end
        OP_L_WR: i <= i + 1'b1;
        OP_I_INC: i <= i + 1'b1;
        OP_CL_START: begin
          i       <= '0;
          rej_cnt <= '0;
          rej_sum <= '0;
        end
        OP_CL_WR: begin
          i <= i + 1'b1;
          if (!kept_q) begin
            rej_cnt <= rej_cnt + 1'b1;
            rej_sum <= rej_sum + w32[27:0];
          end
        end
        OP_EMIT_SUM: begin
          out_q           <= out_next;
          readout_pointer <= '0;
        end
        OP_EMIT_EDGE: begin
          out_q           <= out_next;
          readout_pointer <= readout_pointer + 1'b1;
        end
        OP_EMIT_END: begin
          out_q <= out_next;
        end
        default: ;
      endcase
    end
  end

  assign out_item = out_q;

  assign sts.out_free   = !out_valid || out_ready;
  assign sts.vc_last    = (vc == VB'(MAX_VERTICES - 1));
  assign sts.i_done     = (i == edge_total);
  assign sts.sort_done  = (w >= sn_c);
  assign sts.seg_end    = (k == hi);
  assign sts.p_eq_r     = (pdata == r);
  assign sts.on_dst     = on_dst;
  assign sts.roots_same = (ru == r);
  assign sts.ptr_lt     = (readout_pointer < rej_cnt);

  assert property (@(posedge clk) disable iff (rst) edge_total <= NW'(MAX_EDGES))
    else $error("edge count ran past the store depth");
  assert property (@(posedge clk) disable iff (rst) rej_cnt <= edge_total)
    else $error("more rejected edges than stored edges");
  assert property (@(posedge clk) disable iff (rst) (cmd.op == OP_M_WR) |-> (k < hi))
    else $error("merge wrote past the end of its run");
  assert property (@(posedge clk) disable iff (rst)
      (cmd.op == OP_EMIT_EDGE) |-> (readout_pointer < rej_cnt))
    else $error("readout past the rejected list");

endmodule

// ===== rtl/core/msfcb_ctrl.sv =====
// Controller state machine: sequences load, solve (init, sort, Kruskal,
// collect, sort) and readout. Depends on msfcb_pkg; drives msfcb_datapath.
module msfcb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_action,
  output logic             in_ready,
  input  msfcb_pkg::sts_t  sts,
  output msfcb_pkg::cmd_t  cmd
);
  import msfcb_pkg::*;

  localparam int NS = 29;

  typedef enum logic [NS-1:0] {
    S_IDLE    = NS'(1) << 0,
    S_INIT    = NS'(1) << 1,
    S_B_CHK   = NS'(1) << 2,
    S_B_RD    = NS'(1) << 3,
    S_B_WR    = NS'(1) << 4,
    S_S_CHK   = NS'(1) << 5,
    S_SEG     = NS'(1) << 6,
    S_M_RD    = NS'(1) << 7,
    S_M_WR    = NS'(1) << 8,
    S_M_CHK   = NS'(1) << 9,
    S_K_CHK   = NS'(1) << 10,
    S_K_KEY   = NS'(1) << 11,
    S_K_EDGE  = NS'(1) << 12,
    S_F_START = NS'(1) << 13,
    S_F_RD    = NS'(1) << 14,
    S_F_CHK   = NS'(1) << 15,
    S_C_RD    = NS'(1) << 16,
    S_C_CHK   = NS'(1) << 17,
    S_K_CMP   = NS'(1) << 18,
    S_L_RD    = NS'(1) << 19,
    S_L_WR    = NS'(1) << 20,
    S_CL_CHK  = NS'(1) << 21,
    S_CL_RD   = NS'(1) << 22,
    S_CL_WR   = NS'(1) << 23,
    S_SUM     = NS'(1) << 24,
    S_R_KEY   = NS'(1) << 25,
    S_R_EDGE  = NS'(1) << 26,
    S_R_OUT   = NS'(1) << 27,
    S_R_END   = NS'(1) << 28
  } state_t;

  state_t state, state_next;
  logic   phase, phase_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd.op     = OP_IDLE;
    cmd.phase  = phase;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_LOAD) begin
            cmd.op = OP_LOAD;
          end else if (in_action == ACT_SOLVE) begin
            cmd.op     = OP_INIT_START;
            state_next = S_INIT;
          end else if (in_action == ACT_READ) begin
            state_next = sts.ptr_lt ? S_R_KEY : S_R_END;
          end
        end
      end
      S_INIT: begin
        cmd.op = OP_INIT;
        if (sts.vc_last) state_next = S_B_CHK;
      end
      S_B_CHK: begin
        if (sts.i_done) begin
          cmd.op     = OP_SORT_START;
          cmd.phase  = 1'b0;
          phase_next = 1'b0;
          state_next = S_S_CHK;
        end else begin
          state_next = S_B_RD;
        end
      end
      S_B_RD: begin
        cmd.op     = OP_B_RD;
        state_next = S_B_WR;
      end
      S_B_WR: begin
        cmd.op     = OP_B_WR;
        state_next = S_B_CHK;
      end
      S_S_CHK: begin
        if (!sts.sort_done) begin
          state_next = S_SEG;
        end else if (!phase) begin
          cmd.op     = OP_IDX_CLR;
          state_next = S_K_CHK;
        end else begin
          state_next = S_SUM;
        end
      end
      S_SEG: begin
        cmd.op     = OP_SEG;
        state_next = S_M_RD;
      end
      S_M_RD: begin
        cmd.op     = OP_M_RD;
        state_next = S_M_WR;
      end
      S_M_WR: begin
        cmd.op     = OP_M_WR;
        state_next = S_M_CHK;
      end
      S_M_CHK: begin
        if (sts.seg_end) begin
          cmd.op     = OP_M_NEXT;
          state_next = S_S_CHK;
        end else begin
          state_next = S_M_RD;
        end
      end
      S_K_CHK: begin
        if (sts.i_done) begin
          cmd.op     = OP_CL_START;
          state_next = S_CL_CHK;
        end else begin
          state_next = S_K_KEY;
        end
      end
      S_K_KEY: begin
        cmd.op     = OP_K_KEY;
        state_next = S_K_EDGE;
      end
      S_K_EDGE: begin
        cmd.op     = OP_K_EDGE;
        state_next = S_F_START;
      end
      S_F_START: begin
        cmd.op     = OP_F_START;
        state_next = S_F_RD;
      end
      S_F_RD: begin
        cmd.op     = OP_F_RD;
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        cmd.op     = OP_F_CHK;
        state_next = sts.p_eq_r ? S_C_RD : S_F_RD;
      end
      S_C_RD: begin
        cmd.op     = OP_C_RD;
        state_next = S_C_CHK;
      end
      S_C_CHK: begin
        cmd.op = OP_C_CHK;
        if (!sts.p_eq_r) state_next = S_C_RD;
        else state_next = sts.on_dst ? S_K_CMP : S_F_START;
      end
      S_K_CMP: begin
        if (sts.roots_same) begin
          cmd.op     = OP_I_INC;
          state_next = S_K_CHK;
        end else begin
          state_next = S_L_RD;
        end
      end
      S_L_RD: begin
        cmd.op     = OP_L_RD;
        state_next = S_L_WR;
      end
      S_L_WR: begin
        cmd.op     = OP_L_WR;
        state_next = S_K_CHK;
      end
      S_CL_CHK: begin
        if (sts.i_done) begin
          cmd.op     = OP_SORT_START;
          cmd.phase  = 1'b1;
          phase_next = 1'b1;
          state_next = S_S_CHK;
        end else begin
          state_next = S_CL_RD;
        end
      end
      S_CL_RD: begin
        cmd.op     = OP_CL_RD;
        state_next = S_CL_WR;
      end
      S_CL_WR: begin
        cmd.op     = OP_CL_WR;
        state_next = S_CL_CHK;
      end
      S_SUM: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT_SUM;
          state_next = S_IDLE;
        end
      end
      S_R_KEY: begin
        cmd.op     = OP_R_KEY;
        state_next = S_R_EDGE;
      end
      S_R_EDGE: begin
        cmd.op     = OP_R_EDGE;
        state_next = S_R_OUT;
      end
      S_R_OUT: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT_EDGE;
          state_next = S_IDLE;
        end
      end
      S_R_END: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT_END;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

// ===== rtl/core/max_spanning_forest_cycle_break.sv =====
// Top level of the maximum spanning forest cycle breaker.
// Depends on msfcb_pkg, msfcb_if, msfcb_ctrl and msfcb_datapath.
//
//   channel    dir  handshake      payload
//   items      in   valid/ready    action, src_vertex, dst_vertex, edge_weight
//   results    out  valid/ready    result_kind .. is_last
//   cfg_wr_*   in   write enable   vertex_count
//
// A load is taken while the controller is idle. A read looks up the next
// sort key, then the edge that it names, and registers the result. A solve
// seeds all MAX_VERTICES entries of the union-find memory, builds keys,
// merge sorts them in ceil(log2 n) passes, runs Kruskal over each edge with
// path compression, collects the rejected edges and sorts those. Requests are
// taken only while the controller is idle; a result waits in the output
// register and the controller holds its final state until that register is free.
// Reset is synchronous and clears the edge count, flags and readout state.
module max_spanning_forest_cycle_break #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [msfcb_pkg::VCOUNT_W-1:0] cfg_wr_data,
  msfcb_in_if.sink                       items,
  msfcb_out_if.source                    results
);
  import msfcb_pkg::*;

  cmd_t cmd;
  sts_t sts;

  msfcb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_action (items.data.action),
    .in_ready  (items.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  msfcb_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (items.data),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (results.ready),
    .out_valid   (results.valid),
    .out_item    (results.data)
  );

endmodule
